[rtl/smx_pkg.sv]
`timescale 1ns / 1ps

package smx_pkg;

    localparam int SMX_STACK_DEPTH = 1024;

    // Instruction characters.
    localparam logic [7:0] OP_ADD     = 8'h2B;  // '+'
    localparam logic [7:0] OP_MUL     = 8'h2A;  // '*'
    localparam logic [7:0] OP_NEG     = 8'h2D;  // '-'
    localparam logic [7:0] OP_DIGIT0  = 8'h30;  // '0'
    localparam logic [7:0] OP_DIGIT9  = 8'h39;  // '9'
    localparam logic [7:0] OP_CORE_ID = 8'h6E;  // 'n'
    localparam logic [7:0] OP_BRANCH  = 8'h42;  // 'B'
    localparam logic [7:0] OP_DROP    = 8'h43;  // 'C'
    localparam logic [7:0] OP_DUP     = 8'h44;  // 'D'
    localparam logic [7:0] OP_SWAP    = 8'h45;  // 'E'
    localparam logic [7:0] OP_GET     = 8'h47;  // 'G'
    localparam logic [7:0] OP_PUT     = 8'h50;  // 'P'

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_ILLEGAL   = 2'd3
    } smx_err_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [63:0] read_data;
    } smx_in_t;

    typedef struct packed {
        logic signed [63:0] top_value;
        logic signed [63:0] jump_offset;
        logic               put_valid;
        logic [63:0]        put_data;
        logic [1:0]         error_code;
        logic [10:0]        stack_depth;
    } smx_out_t;

    typedef struct packed {
        logic en;
        logic we;
    } smx_ram_ctl_t;

endpackage

[rtl/smx_stack_ram.sv]
`timescale 1ns / 1ps

// Single-port stack memory with a registered read port.
module smx_stack_ram #(
    parameter int DEPTH = smx_pkg::SMX_STACK_DEPTH - 2
) (
    input  logic                       clk,
    input  smx_pkg::smx_ram_ctl_t      ctl,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic [63:0]                wdata,
    output logic [63:0]                rdata
);
    import smx_pkg::*;

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[rtl/smx_mul64.sv]
`timescale 1ns / 1ps

// Low 64 bits of a 64 x 64 product, built from three 32 x 32 partial
// products through one shared multiplier.
module smx_mul64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic        done,
    output logic [63:0] product
);

    typedef enum logic [4:0] {
        MUL_IDLE = 5'b00001,
        MUL_LL   = 5'b00010,
        MUL_LH   = 5'b00100,
        MUL_HL   = 5'b01000,
        MUL_SUM  = 5'b10000
    } mul_state_t;

    mul_state_t  state_reg, state_next;
    logic [63:0] a_reg, b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] op_x, op_y;
    logic [63:0] mul_out;

    always_comb
    begin
        unique case (state_reg)
            MUL_LH:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            MUL_HL:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
            default:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
        endcase
    end

    assign mul_out = op_x * op_y;

    always_comb
    begin
        unique case (state_reg)
            MUL_IDLE: state_next = start ? MUL_LL : MUL_IDLE;
            MUL_LL:   state_next = MUL_LH;
            MUL_LH:   state_next = MUL_HL;
            MUL_HL:   state_next = MUL_SUM;
            MUL_SUM:  state_next = MUL_IDLE;
            default:  state_next = MUL_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == MUL_IDLE)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        prod_reg <= mul_out;
        if (state_reg == MUL_LH)
        begin
            acc_reg <= prod_reg;
        end
        else if (state_reg == MUL_HL)
        begin
            acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
        end
    end

    assign busy    = (state_reg != MUL_IDLE);
    assign done    = (state_reg == MUL_SUM);
    assign product = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};

endmodule

[rtl/smx_out_buf.sv]
`timescale 1ns / 1ps

// Output register with a skid stage behind it.
module smx_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  smx_pkg::smx_out_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_stall,
    output smx_pkg::smx_out_t out_data
);
    import smx_pkg::*;

    logic     out_valid_reg, skid_valid_reg;
    smx_out_t out_data_reg, skid_data_reg;
    logic     take;

    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/stack_machine_execute_unit.sv]
`timescale 1ns / 1ps

// Execute unit of a 64-bit stack machine: one instruction character per beat.
// Input channel (in_valid / in_stall / in_data) carries an opcode and the
// value that G pushes; a beat moves when in_valid is high and in_stall low.
// Every input beat yields exactly one result beat on the output channel
// (out_valid / out_stall / out_data) with the new top, depth, jump offset,
// put data and an error code. A step that raises an error changes nothing.
// The core id is written through cfg_valid / cfg_ready / cfg_data, which is
// always ready; write it only while no instruction is in flight.
// Pushes, negate, swap and pops from a stack of two or fewer entries let the
// next instruction in at once, and their result enters the output queue as
// they are accepted. Other pops hold off the next instruction until the
// stack memory's single port has refilled the cached second entry.
// A multiply holds the input while one 32 x 32 multiplier is used three times
// and then summed. Results queue in an output register plus a skid stage,
// so the input keeps flowing while one result waits; a second waiting
// result stalls the input. Reset empties the stack and the output queue and
// clears the core id; the stack memory is not cleared and needs no pass.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = smx_pkg::SMX_STACK_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  smx_pkg::smx_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output smx_pkg::smx_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import smx_pkg::*;

    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    // The two top entries live in registers, so the memory holds the rest.
    localparam int RAM_DEPTH = STACK_DEPTH - 2;
    localparam int AW        = $clog2(RAM_DEPTH);
    localparam logic [SPW-1:0] FULL_SP = SPW'(STACK_DEPTH);

    // Stack state: depth, cached top and second entries, refill flag.
    logic [SPW-1:0] sp_reg, sp_next;
    logic [63:0]    tos_reg, tos_next;
    logic [63:0]    nos_reg, nos_next;
    logic           rd_pending_reg, rd_pending_next;
    logic [7:0]     core_id_reg;

    logic [SPW-1:0] sp_inc, sp_dec, sp_m2, sp_m3;

    // Decode results.
    logic [7:0]  op;
    logic [1:0]  need;
    logic        pushes;
    logic        legal;
    smx_err_t    err;
    logic [7:0]  digit_val;
    logic [63:0] push_val;

    logic accept;
    logic exec_ok;

    // Memory port.
    smx_ram_ctl_t  ram_ctl;
    logic [AW-1:0] ram_addr;
    logic [63:0]   ram_wdata;
    logic [63:0]   ram_rdata;

    // Multiplier.
    logic        mul_start;
    logic        mul_busy;
    logic        mul_done;
    logic [63:0] mul_product;

    // Result path.
    logic        res_push;
    smx_out_t    res_data;
    logic [63:0] jump_val;
    logic        put_v;
    logic [63:0] put_d;
    logic        buf_space;

    assign op        = in_data.opcode;
    assign sp_inc    = sp_reg + 1'b1;
    assign sp_dec    = sp_reg - 1'b1;
    assign sp_m2     = sp_reg - SPW'(2);
    assign sp_m3     = sp_reg - SPW'(3);
    assign digit_val = op - OP_DIGIT0;

    // The input waits while the multiplier runs, while a refill read is in
    // flight, and while the skid stage already holds a result.
    assign in_stall  = mul_busy || rd_pending_reg || !buf_space;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        need   = 2'd0;
        pushes = 1'b0;
        legal  = 1'b1;
        unique case (op) inside
            OP_ADD, OP_MUL, OP_BRANCH, OP_SWAP:
            begin
                need = 2'd2;
            end
            OP_NEG, OP_DROP, OP_PUT:
            begin
                need = 2'd1;
            end
            OP_DUP:
            begin
                need   = 2'd1;
                pushes = 1'b1;
            end
            OP_CORE_ID, OP_GET, [OP_DIGIT0:OP_DIGIT9]:
            begin
                pushes = 1'b1;
            end
            default:
            begin
                legal = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (!legal)
        begin
            err = ERR_ILLEGAL;
        end
        else if (sp_reg < SPW'(need))
        begin
            err = ERR_UNDERFLOW;
        end
        else if (pushes && sp_reg >= FULL_SP)
        begin
            err = ERR_OVERFLOW;
        end
        else
        begin
            err = ERR_OK;
        end
    end

    assign exec_ok = accept && (err == ERR_OK);

    always_comb
    begin
        case (op)
            OP_CORE_ID: push_val = {56'd0, core_id_reg};
            OP_GET:     push_val = in_data.read_data;
            OP_DUP:     push_val = tos_reg;
            default:    push_val = {56'd0, digit_val};
        endcase
    end

    // Execute: the top two entries are worked on in registers. A push spills
    // the old second entry to memory; a pop refills it with a memory read
    // whose data lands in the next cycle.
    always_comb
    begin
        tos_next        = tos_reg;
        nos_next        = rd_pending_reg ? ram_rdata : nos_reg;
        sp_next         = sp_reg;
        ram_ctl         = '0;
        ram_addr        = sp_m2[AW-1:0];
        ram_wdata       = nos_reg;
        rd_pending_next = 1'b0;
        mul_start       = 1'b0;
        jump_val        = 64'd0;
        put_v           = 1'b0;
        put_d           = 64'd0;

        if (exec_ok)
        begin
            if (pushes)
            begin
                if (sp_reg >= SPW'(2))
                begin
                    ram_ctl.en = 1'b1;
                    ram_ctl.we = 1'b1;
                end
                nos_next = tos_reg;
                tos_next = push_val;
                sp_next  = sp_inc;
            end
            else
            begin
                case (op)
                    OP_NEG:
                    begin
                        tos_next = 64'd0 - tos_reg;
                    end
                    OP_SWAP:
                    begin
                        tos_next = nos_reg;
                        nos_next = tos_reg;
                    end
                    default:
                    begin
                        // Add, multiply, branch, drop and put all pop one.
                        sp_next = sp_dec;
                        case (op)
                            OP_ADD:
                            begin
                                tos_next = tos_reg + nos_reg;
                            end
                            OP_MUL:
                            begin
                                mul_start = 1'b1;
                            end
                            OP_BRANCH:
                            begin
                                tos_next = nos_reg;
                                jump_val = (nos_reg != 64'd0) ? tos_reg : 64'd0;
                            end
                            OP_PUT:
                            begin
                                tos_next = nos_reg;
                                put_v    = 1'b1;
                                put_d    = tos_reg;
                            end
                            default:
                            begin
                                tos_next = nos_reg;
                            end
                        endcase
                        if (sp_reg >= SPW'(3))
                        begin
                            ram_ctl.en      = 1'b1;
                            ram_addr        = sp_m3[AW-1:0];
                            rd_pending_next = 1'b1;
                        end
                    end
                endcase
            end
        end

        if (mul_done)
        begin
            tos_next = mul_product;
        end
    end

    // A multiply reports when its product is ready; every other instruction,
    // and any step that fails a check, reports in the cycle it is accepted.
    assign res_push = (accept && !(exec_ok && op == OP_MUL)) || mul_done;

    always_comb
    begin
        res_data.top_value   = (sp_next == '0) ? 64'd0 : tos_next;
        res_data.jump_offset = jump_val;
        res_data.put_valid   = put_v;
        res_data.put_data    = put_d;
        res_data.error_code  = mul_done ? ERR_OK : err;
        res_data.stack_depth = 11'(sp_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg         <= '0;
            rd_pending_reg <= 1'b0;
            core_id_reg    <= 8'd0;
        end
        else
        begin
            sp_reg         <= sp_next;
            rd_pending_reg <= rd_pending_next;
            if (cfg_valid)
            begin
                core_id_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        nos_reg <= nos_next;
    end

    smx_stack_ram #(
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    smx_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (tos_reg),
        .b       (nos_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    smx_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .space     (buf_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A result must always find a free slot in the output queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> buf_space)
        else $error("result produced while the output queue is full");

    // The depth never goes past the stack size.
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= FULL_SP)
        else $error("stack pointer beyond stack depth");

    // A successful push grows the stack by exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec_ok && pushes) |=> (sp_reg == $past(sp_inc)))
        else $error("push did not advance the stack pointer");

    // A failing instruction leaves the depth untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err != ERR_OK) |=> (sp_reg == $past(sp_reg)))
        else $error("failing instruction changed the stack depth");

endmodule
